// ===== src/kwm_pkg.sv =====
// Shared types and constants for the keyword list matcher.
package kwm_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned COUNT_W = 10;

  // Item kinds.
  localparam logic KIND_LIST  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Characters with a special role.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam int unsigned CHAR_CODES = 256;

  // Micro-operations that the controller asks of the datapath.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LIST,
    OP_QUERY,
    OP_SORT_INIT,
    OP_RD_WS_I,
    OP_KEY,
    OP_RD_WS_J,
    OP_CMP_INIT,
    OP_RD_PA,
    OP_RD_PB,
    OP_CMP_STEP,
    OP_SHIFT,
    OP_PLACE,
    OP_IX_INIT,
    OP_RD_WS_K,
    OP_RD_LIST_WS,
    OP_IX_WRITE,
    OP_SORTED,
    OP_RD_Q0,
    OP_RD_FBI_FC,
    OP_RD_FBI_CARET,
    OP_J_FBI,
    OP_RD_WS_JJ,
    OP_RD_LIST_WSJ,
    OP_WALK_INIT,
    OP_WALK_INIT_P,
    OP_RD_WALK,
    OP_WALK_STEP,
    OP_NEXT_J,
    OP_FOUND,
    OP_NOTFOUND,
    OP_EMIT
  } kwm_op_t;

  // Command from the controller.
  typedef struct packed {
    kwm_op_t op;
    logic    in_ready;
  } kwm_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic in_last;
    logic q_reject;
    logic sorted;
    logic i_done;
    logic j1_zero;
    logic cmp_cont;
    logic cmp_gt;
    logic k_zero;
    logic vflag;
    logic j_end;
    logic byte_is_fc;
    logic byte_is_caret;
    logic byte_zero;
    logic walk_cont;
    logic exact_hit;
    logic out_busy;
  } kwm_status_t;

endpackage

// ===== src/kwm_if.sv =====
// Item and result channel interfaces of the keyword list matcher.
interface kwm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [kwm_pkg::DATA_W-1:0] data_byte;
  logic                       last;

  modport source (output valid, kind, data_byte, last, input ready);
  modport sink (input valid, kind, data_byte, last, output ready);
endinterface

interface kwm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [kwm_pkg::INDEX_W-1:0] word_index;
  logic [kwm_pkg::COUNT_W-1:0] word_count;
  logic                        list_overflow;
  logic                        query_too_long;

  modport source (output valid, found, word_index, word_count, list_overflow,
                  query_too_long, input ready);
  modport sink (input valid, found, word_index, word_count, list_overflow,
                query_too_long, output ready);
endinterface

// ===== src/keyword_list_matcher.sv =====
// Keyword list matcher: a byte-loaded keyword table answered one query word at a time.
// A list or query byte is taken when idle; a list end or a rejected query goes to the emit
// state, which sends its result once the channel is free. Otherwise a query end first sorts
// the list if it changed (insertion sort through the single list read port), builds the
// first-byte index, then walks candidates byte by byte. Reset is synchronous: the list is
// empty, nothing needs a clearing pass, and the separator mode is space, tab, CR and LF.
module keyword_list_matcher #(
  parameter int unsigned LIST_BYTES  = 4096,
  parameter int unsigned MAX_WORDS   = 512,
  parameter int unsigned QUERY_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  kwm_in_if.sink    item_in,
  kwm_out_if.source result_out
);
  import kwm_pkg::*;

  kwm_cmd_t    cmd;
  kwm_status_t st;

  kwm_ctrl u_ctrl (
    .clk, .rst, .st, .cmd
  );

  kwm_datapath #(
    .LIST_BYTES(LIST_BYTES), .MAX_WORDS(MAX_WORDS), .QUERY_BYTES(QUERY_BYTES)
  ) u_dp (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .cmd, .st, .item_in, .result_out
  );
endmodule

// ===== src/kwm_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module kwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/kwm_datapath.sv =====
// Datapath of the keyword list matcher: list, word and query stores, index and walk registers.
module kwm_datapath #(
  parameter int unsigned LIST_BYTES  = 4096,
  parameter int unsigned MAX_WORDS   = 512,
  parameter int unsigned QUERY_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  kwm_pkg::kwm_cmd_t    cmd,
  output kwm_pkg::kwm_status_t st,
  kwm_in_if.sink               item_in,
  kwm_out_if.source            result_out
);
  import kwm_pkg::*;

  localparam int unsigned LAW = $clog2(LIST_BYTES);
  localparam int unsigned LA  = $clog2(LIST_BYTES + 1);
  localparam int unsigned WA  = $clog2(MAX_WORDS);
  localparam int unsigned WC  = $clog2(MAX_WORDS + 1);
  localparam int unsigned QA  = QUERY_BYTES > 1 ? $clog2(QUERY_BYTES) : 1;
  localparam int unsigned QL  = $clog2(QUERY_BYTES + 1);

  // Control state.
  logic                  leo;
  logic                  load_open;
  logic [LA-1:0]         lpos;
  logic [WC-1:0]         words;
  logic                  prev_sep;
  logic                  ovf;
  logic                  sorted;
  logic [QL-1:0]         qlen;
  logic                  qover;
  logic [CHAR_CODES-1:0] idx_vld;
  logic                  out_valid;

  // Working registers.
  logic [WC-1:0]  i, j1, k1, j;
  logic [LAW-1:0] key, cur;
  logic [LA-1:0]  pa, pb, a;
  logic [QL-1:0]  b;
  logic [7:0]     ba, fc;
  logic           vflag, lst_ok;
  logic           res_found, res_tl;
  logic [INDEX_W-1:0] res_idx;
  logic [INDEX_W-1:0] o_idx;
  logic [COUNT_W-1:0] o_count;
  logic           o_found, o_ovf, o_tl;

  // Memory ports.
  logic           l_we;
  logic [LAW-1:0] l_waddr;
  logic [7:0]     l_wdata, l_rdata;
  logic [LA-1:0]  l_raddr;
  logic           w_we;
  logic [WA-1:0]  w_waddr, w_raddr;
  logic [LAW-1:0] w_wdata, w_rdata;
  logic           q_we;
  logic [QA-1:0]  q_raddr;
  logic [7:0]     q_rdata;
  logic           f_we;
  logic [7:0]     f_raddr;
  logic [WA-1:0]  f_rdata;

  // List byte decode with the state that a fresh load starts from.
  logic          open0, ps, sep, start, room, wroom;
  logic [LA-1:0] lp;
  logic [WC-1:0] wn;
  logic [7:0]    cur_byte;
  logic          q_reject;

  assign open0 = !load_open;
  assign lp    = open0 ? '0 : lpos;
  assign wn    = open0 ? '0 : words;
  assign ps    = open0 ? 1'b1 : prev_sep;
  assign sep   = (item_in.data_byte == CH_CR) || (item_in.data_byte == CH_LF) ||
                 (!leo && ((item_in.data_byte == CH_SPACE) || (item_in.data_byte == CH_TAB)));
  assign room  = lp < LA'(LIST_BYTES);
  assign start = room && !sep && ps;
  assign wroom = wn < WC'(MAX_WORDS);
  assign q_reject = qover || (qlen >= QL'(QUERY_BYTES));

  // A list byte reads as zero past the load position.
  assign cur_byte = lst_ok ? l_rdata : 8'h00;

  // Memory address and write selection.
  always_comb begin
    l_raddr = pa;
    w_raddr = j[WA-1:0];
    q_raddr = '0;
    f_raddr = q_rdata;
    case (cmd.op)
      OP_RD_PA:        l_raddr = pa;
      OP_RD_PB:        l_raddr = pb;
      OP_RD_LIST_WS:   l_raddr = LA'(w_rdata);
      OP_RD_LIST_WSJ:  l_raddr = LA'(w_rdata);
      OP_RD_WALK: begin
        l_raddr = a;
        q_raddr = b[QA-1:0];
      end
      OP_RD_WS_I:      w_raddr = i[WA-1:0];
      OP_RD_WS_J:      w_raddr = WA'(j1 - 1'b1);
      OP_RD_WS_K:      w_raddr = WA'(k1 - 1'b1);
      OP_RD_FBI_CARET: f_raddr = CH_CARET;
      default: begin
      end
    endcase
  end

  always_comb begin
    l_we    = (cmd.op == OP_LIST) && room;
    l_waddr = lp[LAW-1:0];
    l_wdata = sep ? 8'h00 : item_in.data_byte;
    q_we    = (cmd.op == OP_QUERY) && (qlen < QL'(QUERY_BYTES));
    f_we    = cmd.op == OP_IX_WRITE;
    w_we    = 1'b0;
    w_waddr = wn[WA-1:0];
    w_wdata = lp[LAW-1:0];
    case (cmd.op)
      OP_LIST: w_we = start && wroom;
      OP_SHIFT: begin
        w_we    = 1'b1;
        w_waddr = j1[WA-1:0];
        w_wdata = cur;
      end
      OP_PLACE: begin
        w_we    = 1'b1;
        w_waddr = j1[WA-1:0];
        w_wdata = key;
      end
      default: begin
      end
    endcase
  end

  kwm_ram #(.WIDTH(8), .DEPTH(LIST_BYTES)) u_list (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr[LAW-1:0]), .rdata(l_rdata)
  );

  kwm_ram #(.WIDTH(LAW), .DEPTH(MAX_WORDS)) u_starts (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  kwm_ram #(.WIDTH(8), .DEPTH(QUERY_BYTES)) u_query (
    .clk, .we(q_we), .waddr(qlen[QA-1:0]), .wdata(item_in.data_byte),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  kwm_ram #(.WIDTH(WA), .DEPTH(CHAR_CODES)) u_first (
    .clk, .we(f_we), .waddr(cur_byte), .wdata(WA'(k1 - 1'b1)),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // Control state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      leo       <= 1'b0;
      load_open <= 1'b0;
      lpos      <= '0;
      words     <= '0;
      prev_sep  <= 1'b1;
      ovf       <= 1'b0;
      sorted    <= 1'b0;
      qlen      <= '0;
      qover     <= 1'b0;
      idx_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        leo <= cfg_wr_data;
      end
      // A new result replaces one that leaves at this edge.
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LIST: begin
          load_open <= !item_in.last;
          sorted    <= 1'b0;
          if (open0) begin
            idx_vld <= '0;
          end
          if (room) begin
            lpos     <= lp + 1'b1;
            prev_sep <= sep;
            words    <= (start && wroom) ? wn + 1'b1 : wn;
            ovf      <= (open0 ? 1'b0 : ovf) || (start && !wroom);
          end else begin
            lpos     <= lp;
            prev_sep <= ps;
            words    <= wn;
            ovf      <= 1'b1;
          end
        end
        OP_QUERY: begin
          if (item_in.last && q_reject) begin
            qlen  <= '0;
            qover <= 1'b0;
          end else if (qlen < QL'(QUERY_BYTES)) begin
            qlen <= qlen + 1'b1;
          end else begin
            qover <= 1'b1;
          end
        end
        OP_SORT_INIT: idx_vld <= '0;
        OP_IX_WRITE:  idx_vld[cur_byte] <= 1'b1;
        OP_SORTED:    sorted <= 1'b1;
        OP_FOUND, OP_NOTFOUND: begin
          qlen  <= '0;
          qover <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working register updates.
  always_ff @(posedge clk) begin
    lst_ok <= l_raddr < lpos;
    case (cmd.op)
      OP_LIST: begin
        res_found <= 1'b0;
        res_tl    <= 1'b0;
        res_idx   <= '0;
      end
      OP_QUERY: begin
        res_found <= 1'b0;
        res_tl    <= q_reject;
        res_idx   <= '0;
      end
      OP_SORT_INIT: i <= WC'(1);
      OP_KEY: begin
        key <= w_rdata;
        j1  <= i;
      end
      OP_CMP_INIT: begin
        cur <= w_rdata;
        pa  <= LA'(w_rdata);
        pb  <= LA'(key);
      end
      OP_RD_PB:    ba <= cur_byte;
      OP_CMP_STEP: begin
        pa <= pa + 1'b1;
        pb <= pb + 1'b1;
      end
      OP_SHIFT:    j1 <= j1 - 1'b1;
      OP_PLACE:    i <= i + 1'b1;
      OP_IX_INIT:  k1 <= words;
      OP_IX_WRITE: k1 <= k1 - 1'b1;
      OP_RD_FBI_FC: begin
        fc    <= q_rdata;
        vflag <= idx_vld[q_rdata];
      end
      OP_RD_FBI_CARET: vflag <= idx_vld[CH_CARET];
      OP_J_FBI:       j <= WC'(f_rdata);
      OP_RD_LIST_WSJ: a <= LA'(w_rdata);
      OP_WALK_INIT:   b <= '0;
      OP_WALK_INIT_P: begin
        a <= a + 1'b1;
        b <= '0;
      end
      OP_WALK_STEP: begin
        a <= a + 1'b1;
        b <= b + 1'b1;
      end
      OP_NEXT_J: j <= j + 1'b1;
      OP_FOUND: begin
        res_found <= 1'b1;
        res_idx   <= INDEX_W'(j);
      end
      OP_NOTFOUND: begin
        res_found <= 1'b0;
        res_idx   <= '0;
      end
      OP_EMIT: begin
        o_found <= res_found;
        o_idx   <= res_idx;
        o_count <= COUNT_W'(words);
        o_ovf   <= ovf;
        o_tl    <= res_tl;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    st.in_valid      = item_in.valid;
    st.in_kind       = item_in.kind;
    st.in_last       = item_in.last;
    st.q_reject      = q_reject;
    st.sorted        = sorted;
    st.i_done        = i >= words;
    st.j1_zero       = j1 == '0;
    st.cmp_cont      = (ba != 8'h00) && (ba == cur_byte);
    st.cmp_gt        = $signed(ba) > $signed(cur_byte);
    st.k_zero        = k1 == '0;
    st.vflag         = vflag;
    st.j_end         = j >= words;
    st.byte_is_fc    = cur_byte == fc;
    st.byte_is_caret = cur_byte == CH_CARET;
    st.byte_zero     = cur_byte == 8'h00;
    st.walk_cont     = (b < qlen) && (cur_byte != 8'h00) && (cur_byte == q_rdata);
    st.exact_hit     = (b == qlen) && (cur_byte == 8'h00);
    st.out_busy      = out_valid && !result_out.ready;
  end

  // Channel ports.
  assign item_in.ready             = cmd.in_ready;
  assign result_out.valid          = out_valid;
  assign result_out.found          = o_found;
  assign result_out.word_index     = o_idx;
  assign result_out.word_count     = o_count;
  assign result_out.list_overflow  = o_ovf;
  assign result_out.query_too_long = o_tl;
endmodule

// ===== src/kwm_ctrl.sv =====
// Controller of the keyword list matcher: load, sort, index and search sequencing.
module kwm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  kwm_pkg::kwm_status_t st,
  output kwm_pkg::kwm_cmd_t    cmd
);
  import kwm_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE  = 25'h0000001,
    ST_EMIT  = 25'h0000002,
    ST_SORT0 = 25'h0000004,
    ST_SI    = 25'h0000008,
    ST_KEY   = 25'h0000010,
    ST_J     = 25'h0000020,
    ST_JD    = 25'h0000040,
    ST_CA    = 25'h0000080,
    ST_CB    = 25'h0000100,
    ST_CC    = 25'h0000200,
    ST_IX    = 25'h0000400,
    ST_IXB   = 25'h0000800,
    ST_IXC   = 25'h0001000,
    ST_F0    = 25'h0002000,
    ST_F1    = 25'h0004000,
    ST_F2    = 25'h0008000,
    ST_EJ    = 25'h0010000,
    ST_EJ1   = 25'h0020000,
    ST_EJ2   = 25'h0040000,
    ST_W0    = 25'h0080000,
    ST_W1    = 25'h0100000,
    ST_P0    = 25'h0200000,
    ST_P1    = 25'h0400000,
    ST_PJ    = 25'h0800000,
    ST_PJ1   = 25'h1000000
  } state_t;

  state_t state, state_next;
  logic   pfx, pfx_next;
  logic   caret_chk, caret_chk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pfx       <= 1'b0;
      caret_chk <= 1'b0;
    end else begin
      state     <= state_next;
      pfx       <= pfx_next;
      caret_chk <= caret_chk_next;
    end
  end

  // Next state and micro-operation.
  always_comb begin
    state_next     = state;
    pfx_next       = pfx;
    caret_chk_next = 1'b0;
    cmd.op         = OP_NONE;
    cmd.in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.op = (st.in_kind == KIND_QUERY) ? OP_QUERY : OP_LIST;
          if (st.in_last) begin
            if (st.in_kind == KIND_LIST || st.q_reject) begin
              state_next = ST_EMIT;
            end else if (st.sorted) begin
              state_next = ST_F0;
            end else begin
              state_next = ST_SORT0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      ST_SORT0: begin
        cmd.op     = OP_SORT_INIT;
        state_next = ST_SI;
      end
      // Insertion sort: take the next key, shift larger words up.
      ST_SI: begin
        if (st.i_done) begin
          cmd.op     = OP_IX_INIT;
          state_next = ST_IX;
        end else begin
          cmd.op     = OP_RD_WS_I;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        cmd.op     = OP_KEY;
        state_next = ST_J;
      end
      ST_J: begin
        if (st.j1_zero) begin
          cmd.op     = OP_PLACE;
          state_next = ST_SI;
        end else begin
          cmd.op     = OP_RD_WS_J;
          state_next = ST_JD;
        end
      end
      ST_JD: begin
        cmd.op     = OP_CMP_INIT;
        state_next = ST_CA;
      end
      ST_CA: begin
        cmd.op     = OP_RD_PA;
        state_next = ST_CB;
      end
      ST_CB: begin
        cmd.op     = OP_RD_PB;
        state_next = ST_CC;
      end
      ST_CC: begin
        if (st.cmp_cont) begin
          cmd.op     = OP_CMP_STEP;
          state_next = ST_CA;
        end else if (st.cmp_gt) begin
          cmd.op     = OP_SHIFT;
          state_next = ST_J;
        end else begin
          cmd.op     = OP_PLACE;
          state_next = ST_SI;
        end
      end
      // First-byte index, built from the last word down.
      ST_IX: begin
        if (st.k_zero) begin
          cmd.op     = OP_SORTED;
          state_next = ST_F0;
        end else begin
          cmd.op     = OP_RD_WS_K;
          state_next = ST_IXB;
        end
      end
      ST_IXB: begin
        cmd.op     = OP_RD_LIST_WS;
        state_next = ST_IXC;
      end
      ST_IXC: begin
        cmd.op     = OP_IX_WRITE;
        state_next = ST_IX;
      end
      // Exact search among words with the query's first byte.
      ST_F0: begin
        cmd.op     = OP_RD_Q0;
        state_next = ST_F1;
      end
      ST_F1: begin
        cmd.op     = OP_RD_FBI_FC;
        state_next = ST_F2;
      end
      ST_F2: begin
        if (st.vflag) begin
          cmd.op     = OP_J_FBI;
          state_next = ST_EJ;
        end else begin
          state_next = ST_P0;
        end
      end
      ST_EJ: begin
        if (st.j_end) begin
          state_next = ST_P0;
        end else begin
          cmd.op     = OP_RD_WS_JJ;
          state_next = ST_EJ1;
        end
      end
      ST_EJ1: begin
        cmd.op     = OP_RD_LIST_WSJ;
        state_next = ST_EJ2;
      end
      ST_EJ2: begin
        if (st.byte_is_fc) begin
          cmd.op     = OP_WALK_INIT;
          pfx_next   = 1'b0;
          state_next = ST_W0;
        end else begin
          state_next = ST_P0;
        end
      end
      // Byte walk shared by exact and prefix entries.
      ST_W0: begin
        cmd.op     = OP_RD_WALK;
        state_next = ST_W1;
      end
      ST_W1: begin
        if (st.walk_cont) begin
          cmd.op     = OP_WALK_STEP;
          state_next = ST_W0;
        end else if (pfx ? st.byte_zero : st.exact_hit) begin
          cmd.op     = OP_FOUND;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_NEXT_J;
          state_next = pfx ? ST_PJ : ST_EJ;
        end
      end
      // Prefix search among entries that start with a caret.
      ST_P0: begin
        cmd.op     = OP_RD_FBI_CARET;
        state_next = ST_P1;
      end
      ST_P1: begin
        if (st.vflag) begin
          cmd.op     = OP_J_FBI;
          state_next = ST_PJ;
        end else begin
          cmd.op     = OP_NOTFOUND;
          state_next = ST_EMIT;
        end
      end
      ST_PJ: begin
        if (caret_chk) begin
          if (st.byte_is_caret) begin
            cmd.op     = OP_WALK_INIT_P;
            pfx_next   = 1'b1;
            state_next = ST_W0;
          end else begin
            cmd.op     = OP_NOTFOUND;
            state_next = ST_EMIT;
          end
        end else if (st.j_end) begin
          cmd.op     = OP_NOTFOUND;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_RD_WS_JJ;
          state_next = ST_PJ1;
        end
      end
      ST_PJ1: begin
        cmd.op         = OP_RD_LIST_WSJ;
        caret_chk_next = 1'b1;
        state_next     = ST_PJ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule
